// ----- hw/rtl/uemr_pkg.sv -----
// shared constants and types for the ultrasonic echo median ranger
// no dependencies; imported by every module of the block
package uemr_pkg;

    localparam int DIST_W      = 20;
    localparam int SPAN_W      = 24;
    localparam int MUL_A_W     = 28;
    localparam int MUL_B_W     = 27;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int PRE_SHIFT   = 5;
    localparam int RECIP_SHIFT = 36;

    localparam logic [15:0]        SOUND_CM_PER_S    = 16'd34300;
    localparam logic [20:0]        TICKS_TWICE_PER_S = 21'd2000000;
    localparam logic [DIST_W-1:0]  DIST_MAX          = 20'd287729;

    // cm = ((span * 343) >> 5) / 625, the divide done as a multiply by ceil(2^36 / 625)
    localparam logic [MUL_B_W-1:0] SCALE_NUM = 27'd343;
    localparam logic [MUL_B_W-1:0] RECIP_625 = 27'd109951163;

    localparam int WINDOW_SIZE_DEF = 5;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] cm;
    } t_dist_sts;

endpackage

// ----- hw/rtl/uemr_dist.sv -----
// echo span to distance unit: span, then one shared multiplier used for scale and reciprocal
// depends on uemr_pkg
module uemr_dist (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [15:0]           i_echo_start_tick,
    input  logic [15:0]           i_echo_end_tick,
    input  logic [7:0]            i_echo_overflows,
    output uemr_pkg::t_dist_sts   o_sts
);
    import uemr_pkg::*;

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_MUL  = 2'd1;
    localparam logic [1:0] D_RCP  = 2'd2;
    localparam logic [1:0] D_DONE = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [SPAN_W-1:0]  r_span;
    logic [SPAN_W-1:0]  w_top, w_base, w_span;
    logic [MUL_A_W-1:0] r_scaled;
    logic [DIST_W-1:0]  r_quo;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [PROD_W-1:0]  w_prod;

    assign w_top  = {i_echo_overflows, i_echo_end_tick};
    assign w_base = {8'd0, i_echo_start_tick};
    assign w_span = (w_top > w_base) ? (w_top - w_base) : '0;

    assign w_mul_a = (r_state == D_MUL) ? MUL_A_W'(r_span) : r_scaled;
    assign w_mul_b = (r_state == D_MUL) ? SCALE_NUM : RECIP_625;
    assign w_prod  = w_mul_a * w_mul_b;

    always_comb begin
        n_state = r_state;
        case (r_state)
            D_IDLE: begin
                if (i_start) n_state = D_MUL;
            end
            D_MUL:  n_state = D_RCP;
            D_RCP:  n_state = D_DONE;
            D_DONE: n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            D_IDLE: begin
                if (i_start) r_span <= w_span;
            end
            D_MUL: begin
                r_scaled <= w_prod[PRE_SHIFT+MUL_A_W-1:PRE_SHIFT];
            end
            D_RCP: begin
                r_quo <= DIST_W'(w_prod[PROD_W-1:RECIP_SHIFT]);
            end
            default: begin
            end
        endcase
    end

    assign o_sts.done = (r_state == D_DONE);
    assign o_sts.cm   = r_quo;

endmodule

// ----- hw/rtl/ultrasonic_echo_median_ranger.sv -----
// top level of the ultrasonic echo median ranger
// depends on uemr_pkg and uemr_dist
//
// One beat in gives one beat out. A measurement goes from accept to the next
// ready through the distance unit, which registers the span and then runs one
// shared multiplier twice: by 343 to scale the span, then by a reciprocal of
// 625 to finish the divide by the tick rate. A measurement that fills the last
// window slot then runs a rank search: a single comparator ranks each stored
// distance against the rotating window to pick the middle value(s). A restart
// beat skips the distance unit. The result sits in an output register; the
// next beat is taken while it waits, and a beat that finishes while that
// result is still unread holds the block until it is taken.
module ultrasonic_echo_median_ranger #(
    parameter int WINDOW_SIZE = uemr_pkg::WINDOW_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [15:0]                 i_echo_start_tick,
    input  logic [15:0]                 i_echo_end_tick,
    input  logic [7:0]                  i_echo_overflows,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [uemr_pkg::DIST_W-1:0] o_distance_now,
    output logic [uemr_pkg::DIST_W-1:0] o_median_distance,
    output logic                        o_median_new
);
    import uemr_pkg::*;

    localparam int IDX_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int STEP_W = $clog2(WINDOW_SIZE + 2);
    localparam int K_LO   = (WINDOW_SIZE - 1) / 2;
    localparam int K_HI   = WINDOW_SIZE / 2;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_MED  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [DIST_W-1:0] r_win [WINDOW_SIZE];
    logic [IDX_W-1:0]  r_index;
    logic [DIST_W-1:0] r_held;
    logic [DIST_W-1:0] r_dist;
    logic              r_fresh;
    logic [DIST_W-1:0] r_cand_val;
    logic [CNT_W-1:0]  r_less, r_le;
    logic [STEP_W-1:0] r_step;
    logic [IDX_W-1:0]  r_cand;
    logic [DIST_W-1:0] r_lo, r_hi;
    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_dist, r_out_med;
    logic              r_out_new;

    t_dist_sts         w_sts;
    logic              w_accept, w_start, w_last, w_lt, w_eq, w_out_free;
    logic              w_sel_end, w_cand_end;
    logic [DIST_W:0]   w_sum;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_start    = w_accept && (i_operation == OP_MEASURE);
    assign w_last     = (r_index == IDX_W'(WINDOW_SIZE - 1));
    assign w_lt       = (r_win[0] < r_cand_val);
    assign w_eq       = (r_win[0] == r_cand_val);
    assign w_sum      = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_sel_end  = (r_step == STEP_W'(WINDOW_SIZE + 1));
    assign w_cand_end = (r_cand == IDX_W'(WINDOW_SIZE - 1));

    uemr_dist u_dist (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (w_start),
        .i_echo_start_tick (i_echo_start_tick),
        .i_echo_end_tick   (i_echo_end_tick),
        .i_echo_overflows  (i_echo_overflows),
        .o_sts             (w_sts)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_operation == OP_RESTART) ? S_DONE : S_CALC;
                end
            end
            S_CALC: begin
                if (w_sts.done) n_state = w_last ? S_SEL : S_DONE;
            end
            S_SEL: begin
                if (w_sel_end && w_cand_end) n_state = S_MED;
            end
            S_MED:  n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_index     <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && (i_operation == OP_RESTART)) begin
                r_index <= '0;
                r_held  <= '0;
            end
            if ((r_state == S_CALC) && w_sts.done) begin
                r_index <= w_last ? '0 : r_index + 1'b1;
            end
            if (r_state == S_MED) begin
                r_held <= w_sum[DIST_W:1];
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // window, rank search and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_operation == OP_RESTART)) begin
                    r_dist  <= '0;
                    r_fresh <= 1'b0;
                end
            end
            S_CALC: begin
                if (w_sts.done) begin
                    r_dist   <= w_sts.cm;
                    r_fresh  <= w_last;
                    r_step   <= '0;
                    r_cand   <= '0;
                    r_win[0] <= w_sts.cm;
                    for (int i = 1; i < WINDOW_SIZE; i++) begin
                        r_win[i] <= r_win[i-1];
                    end
                end
            end
            S_SEL: begin
                if (r_step == '0) begin
                    r_cand_val <= r_win[0];
                    r_less     <= '0;
                    r_le       <= '0;
                    r_step     <= r_step + 1'b1;
                end else begin
                    for (int i = 0; i < WINDOW_SIZE; i++) begin
                        r_win[i] <= r_win[(i + 1) % WINDOW_SIZE];
                    end
                    if (w_sel_end) begin
                        if ((r_less <= CNT_W'(K_LO)) && (CNT_W'(K_LO) < r_le)) begin
                            r_lo <= r_cand_val;
                        end
                        if ((r_less <= CNT_W'(K_HI)) && (CNT_W'(K_HI) < r_le)) begin
                            r_hi <= r_cand_val;
                        end
                        r_step <= '0;
                        r_cand <= r_cand + 1'b1;
                    end else begin
                        r_less <= r_less + CNT_W'(w_lt);
                        r_le   <= r_le + CNT_W'(w_lt || w_eq);
                        r_step <= r_step + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_dist <= r_dist;
                    r_out_med  <= r_held;
                    r_out_new  <= r_fresh;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_distance_now    = r_out_dist;
    assign o_median_distance = r_out_med;
    assign o_median_new      = r_out_new;

endmodule

// ----- hw/rtl/uemr_checker.sv -----
// port level checks for the ultrasonic echo median ranger, bound to the top level
// depends on uemr_pkg and ultrasonic_echo_median_ranger
module uemr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [uemr_pkg::DIST_W-1:0] o_distance_now,
    input logic [uemr_pkg::DIST_W-1:0] o_median_distance
);
    import uemr_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_distance_now) && $stable(o_median_distance))
        else $error("result beat changed while stalled");

    // one beat at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // distance range
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_distance_now <= DIST_MAX) && (o_median_distance <= DIST_MAX))
        else $error("distance beyond largest span");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ultrasonic_echo_median_ranger uemr_checker u_uemr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_distance_now    (o_distance_now),
    .o_median_distance (o_median_distance)
);
